// ===== sv/lckr_pkg.sv =====
// constants, keyword table and helpers shared by the line command keyword receiver
`default_nettype none

package lckr_pkg;

    localparam int LINE_MAX     = 64;
    localparam int CNT_W        = $clog2(LINE_MAX);
    localparam int POS_W        = 6;
    localparam int KEY_COUNT    = 11;
    localparam int KEY_LEN_MAX  = 8;
    localparam int CODE_W       = 4;
    localparam int BYTE_W       = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 8;

    localparam logic [POS_W-1:0]  POS_SAT   = '1;
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(LINE_MAX - 1);

    localparam logic              KIND_BYTE  = 1'b0;
    localparam logic              KIND_FETCH = 1'b1;

    localparam logic [CODE_W-1:0] CODE_NONE  = '0;
    localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(KEY_COUNT);

    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;

    localparam logic [KEY_COUNT-1:0] ALL_ALIVE = '1;

    // keyword text, right justified: last letter in the lowest byte
    localparam logic [8*KEY_LEN_MAX-1:0] KEY_TEXT [KEY_COUNT] = '{
        64'("HAPPY"), 64'("SAD"), 64'("LEFT"), 64'("RIGHT"), 64'("UP"),
        64'("DOWN"), 64'("CENTER"), 64'("BLINK"), 64'("YES"), 64'("NO"),
        64'("NEUTRAL")
    };

    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
        4'd5, 4'd3, 4'd4, 4'd5, 4'd2, 4'd4, 4'd6, 4'd5, 4'd3, 4'd2, 4'd7
    };

    // letter of keyword idx at position pos, valid only for pos below its length
    function automatic logic [BYTE_W-1:0] key_char(input int idx, input logic [2:0] pos);
        logic [2:0] sel;
        sel = KEY_LEN[idx][2:0] - 3'd1 - pos;
        return KEY_TEXT[idx][{sel, 3'b000} +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ===== sv/line_command_keyword_receiver.sv =====
// top level: assembles received bytes into lines and matches them against keywords
//
// usage
//   s_ channel: one word per received byte or fetch request; s_tuser is the kind
//   (0 byte, 1 fetch), s_tdata the byte. control bytes below 32 other than newline
//   are ignored, a newline ends a non-empty line, which goes into a one-slot
//   mailbox if it is empty and is dropped otherwise
//   m_tdata: exactly one result word per input word, in order; bits 3:0 are the
//   keyword code (nonzero only on a fetch of a filled mailbox), bit 4 tells that a
//   line still waits in the mailbox after this word
//   path: the input register takes each accepted word, the result register then takes
//   its result word; throughput one word per cycle while the result channel is not
//   stalled, set by the state update that lies combinationally between the two registers
//   reset: synchronous on aresetn low; both channels empty, line state cleared,
//   mailbox empty
//   stall: with m_tready low the result word holds, the input register takes one
//   more word if it is empty, then s_tready drops until the result is taken
`default_nettype none

module line_command_keyword_receiver
    import lckr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] byte_value
    input  wire logic [0:0]           s_tuser,   // [0] kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [3:0] command_code, [4] pending, rest zero
);

    logic                  in_valid_reg;
    logic                  in_kind_reg;
    logic [BYTE_W-1:0]     in_byte_reg;

    logic                  out_valid_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic                  out_pending_reg;

    logic [CNT_W-1:0]      stored_count_reg,  stored_count_next;
    logic                  word_started_reg,  word_started_next;
    logic                  trailing_seen_reg, trailing_seen_next;
    logic [POS_W-1:0]      word_position_reg, word_position_next;
    logic [KEY_COUNT-1:0]  alive_mask_reg,    alive_mask_next;
    logic [CODE_W-1:0]     mailbox_code_reg,  mailbox_code_next;
    logic                  pending_reg,       pending_next;
    logic [CODE_W-1:0]     code_next;

    logic                  advance;
    logic                  step;
    logic [BYTE_W-1:0]     upper_char;
    logic [KEY_COUNT-1:0]  match_mask;
    logic [CODE_W-1:0]     line_code;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CODE_W - 1)'(0), out_pending_reg, out_code_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    always_comb begin
        upper_char = in_byte_reg;
        if (in_byte_reg >= CHAR_LC_A && in_byte_reg <= CHAR_LC_Z) begin
            upper_char = in_byte_reg - CASE_DIFF;
        end
    end

    // per-keyword compare of the current letter against its position
    always_comb begin
        for (int i = 0; i < KEY_COUNT; i++) begin
            match_mask[i] = alive_mask_reg[i]
                && (word_position_reg < POS_W'(KEY_LEN[i]))
                && (key_char(i, word_position_reg[2:0]) == upper_char);
        end
    end

    // first surviving keyword whose length equals the word length
    always_comb begin
        line_code = CODE_NONE;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (alive_mask_reg[i] && word_position_reg == POS_W'(KEY_LEN[i])) begin
                line_code = CODE_W'(i + 1);
            end
        end
        if (!word_started_reg) begin
            line_code = CODE_NONE;
        end
    end

    always_comb begin
        stored_count_next  = stored_count_reg;
        word_started_next  = word_started_reg;
        trailing_seen_next = trailing_seen_reg;
        word_position_next = word_position_reg;
        alive_mask_next    = alive_mask_reg;
        mailbox_code_next  = mailbox_code_reg;
        pending_next       = pending_reg;
        code_next          = CODE_NONE;

        if (in_kind_reg == KIND_FETCH) begin
            if (pending_reg) begin
                code_next         = mailbox_code_reg;
                mailbox_code_next = CODE_NONE;
                pending_next      = 1'b0;
            end
        end else if (in_byte_reg == CHAR_NL) begin
            if (stored_count_reg != '0) begin
                if (!pending_reg) begin
                    mailbox_code_next = line_code;
                    pending_next      = 1'b1;
                end
                stored_count_next  = '0;
                word_started_next  = 1'b0;
                trailing_seen_next = 1'b0;
                word_position_next = '0;
                alive_mask_next    = ALL_ALIVE;
            end
        end else if (in_byte_reg >= CHAR_SP && stored_count_reg < CNT_LIMIT) begin
            stored_count_next = stored_count_reg + 1'b1;
            if (in_byte_reg == CHAR_SP) begin
                if (word_started_reg) begin
                    trailing_seen_next = 1'b1;
                end
            end else if (trailing_seen_reg) begin
                alive_mask_next = '0;
            end else begin
                word_started_next = 1'b1;
                alive_mask_next   = match_mask;
                if (word_position_reg != POS_SAT) begin
                    word_position_next = word_position_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_count_reg  <= '0;
            word_started_reg  <= 1'b0;
            trailing_seen_reg <= 1'b0;
            word_position_reg <= '0;
            alive_mask_reg    <= ALL_ALIVE;
            mailbox_code_reg  <= CODE_NONE;
            pending_reg       <= 1'b0;
        end else if (step) begin
            stored_count_reg  <= stored_count_next;
            word_started_reg  <= word_started_next;
            trailing_seen_reg <= trailing_seen_next;
            word_position_reg <= word_position_next;
            alive_mask_reg    <= alive_mask_next;
            mailbox_code_reg  <= mailbox_code_next;
            pending_reg       <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step) begin
            out_code_reg    <= code_next;
            out_pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lckr_checker.sv =====
// port-level checker for the line command keyword receiver, with its bind
`default_nettype none

module lckr_checker
    import lckr_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // result channel empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // an accepted word is followed by a valid word on the result channel
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted word produced no result");

    // a returned code empties the mailbox
    a_code_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[CODE_W-1:0] != CODE_NONE |-> !m_tdata[CODE_W])
        else $error("code returned while mailbox still pending");

    // code within keyword range, padding zero
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CODE_W-1:0] <= CODE_MAX
                     && m_tdata[M_TDATA_W-1:CODE_W+1] == '0)
        else $error("result word out of range");

endmodule

bind line_command_keyword_receiver lckr_checker u_lckr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/tb_line_command_keyword_receiver.sv =====
// testbench for the line command keyword receiver: directed and random byte streams against a predictor
module tb_line_command_keyword_receiver;
    import lckr_pkg::*;

    localparam int             WATCHDOG_LIMIT = 2000;
    localparam logic [7:0]     CHAR_NUL       = 8'h00;
    localparam logic [7:0]     CHAR_CR        = 8'h0D;
    localparam logic [7:0]     CHAR_UC_A      = 8'h41;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              pending;
    } keyword_reply_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] byte_value
    logic [0:0]           s_tuser;   // [0] kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [3:0] command_code, [4] pending

    line_command_keyword_receiver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    string keyword_list [KEY_COUNT] = '{"HAPPY", "SAD", "LEFT", "RIGHT", "UP", "DOWN",
                                        "CENTER", "BLINK", "YES", "NO", "NEUTRAL"};

    // line assembly state as the receiver should hold it
    int                   kept_bytes;
    logic                 word_begun;
    logic                 tail_space;
    int                   word_pos;
    logic [KEY_COUNT-1:0] live_keys;
    logic [CODE_W-1:0]    mailbox_code;
    logic                 mailbox_full;

    keyword_reply_t awaited_replies [$];
    int             failures;
    int             words_counted;
    int             src_gap_max;
    int             snk_stall_max;
    int             quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_line();
        kept_bytes = 0;
        word_begun = 1'b0;
        tail_space = 1'b0;
        word_pos   = 0;
        live_keys  = '1;
    endfunction

    function automatic keyword_reply_t predict_reply(input logic kind, input logic [7:0] value);
        keyword_reply_t r;
        logic [7:0]     c;
        r.code = CODE_NONE;
        if (kind == KIND_FETCH) begin
            if (mailbox_full) begin
                r.code       = mailbox_code;
                mailbox_code = CODE_NONE;
                mailbox_full = 1'b0;
            end
        end else if (value == CHAR_NL) begin
            if (kept_bytes != 0) begin
                if (!mailbox_full) begin
                    mailbox_code = CODE_NONE;
                    if (word_begun) begin
                        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
                            if (live_keys[i] && keyword_list[i].len() == word_pos)
                                mailbox_code = CODE_W'(i + 1);
                        end
                    end
                    mailbox_full = 1'b1;
                end
                clear_line();
            end
        end else if (value >= CHAR_SP && kept_bytes < LINE_MAX - 1) begin
            kept_bytes++;
            if (value == CHAR_SP) begin
                if (word_begun)
                    tail_space = 1'b1;
            end else if (tail_space) begin
                live_keys = '0;
            end else begin
                word_begun = 1'b1;
                c = (value >= CHAR_LC_A && value <= CHAR_LC_Z) ? value - CASE_DIFF : value;
                for (int i = 0; i < KEY_COUNT; i++) begin
                    if (live_keys[i] && (word_pos >= keyword_list[i].len() ||
                                         8'(keyword_list[i][word_pos]) != c))
                        live_keys[i] = 1'b0;
                end
                if (word_pos < POS_SAT)
                    word_pos++;
            end
        end
        r.pending = mailbox_full;
        return r;
    endfunction

    task automatic count_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    task automatic send_word(input logic kind, input logic [7:0] value);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        awaited_replies.push_back(predict_reply(kind, value));
        words_counted++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_word(KIND_BYTE, value);
    endtask

    task automatic fetch();
        send_word(KIND_FETCH, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(8'(text[i]));
    endtask

    // wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_replies.size() != 0) @(posedge aclk);
    endtask

    // spaces with an ignored control byte now and then
    task automatic send_spaces(input int n);
        logic [7:0] ctl;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                ctl = 8'($urandom_range(0, 31));
                send_byte(ctl == CHAR_NL ? CHAR_CR : ctl);
            end
            send_byte(CHAR_SP);
        end
    endtask

    // keyword letters in random case; mode 1 corrupts a letter, 2 cuts, 3 adds one
    task automatic send_keyword(input int k, input int mode);
        int         len;
        int         spot;
        logic [7:0] ch;
        len  = keyword_list[k].len();
        spot = $urandom_range(0, len - 1);
        if (mode == 2)
            len--;
        for (int i = 0; i < len; i++) begin
            ch = 8'(keyword_list[k][i]);
            if ($urandom_range(0, 1))
                ch = ch + CASE_DIFF;
            if (mode == 1 && i == spot)
                ch = 8'($urandom_range(33, 255));
            send_byte(ch);
        end
        if (mode == 3)
            send_byte(CHAR_UC_A + 8'($urandom_range(0, 25)));
    endtask

    task automatic random_line();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            send_spaces($urandom_range(0, 3));
            send_keyword($urandom_range(0, KEY_COUNT - 1), 0);
            send_spaces($urandom_range(0, 3));
            send_byte(CHAR_NL);
        end else if (sel < 60) begin
            send_spaces($urandom_range(0, 1));
            send_keyword($urandom_range(0, KEY_COUNT - 1), $urandom_range(1, 3));
            send_byte(CHAR_NL);
        end else if (sel < 70) begin
            send_keyword($urandom_range(0, KEY_COUNT - 1), 0);
            send_spaces($urandom_range(1, 2));
            if ($urandom_range(0, 1))
                send_keyword($urandom_range(0, KEY_COUNT - 1), 0);
            else
                send_byte(8'($urandom_range(33, 255)));
            send_byte(CHAR_NL);
        end else if (sel < 80) begin
            n = $urandom_range(0, 12);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else if (sel < 85) begin
            send_spaces($urandom_range(0, 4));
            send_byte(CHAR_NL);
        end else if (sel < 88) begin
            if ($urandom_range(0, 1)) begin
                send_spaces($urandom_range(55, 68));
                send_keyword($urandom_range(0, KEY_COUNT - 1), 0);
            end else begin
                send_keyword($urandom_range(0, KEY_COUNT - 1), 0);
                send_spaces($urandom_range(52, 64));
                send_byte(CHAR_UC_A + 8'($urandom_range(0, 25)));
            end
            send_byte(CHAR_NL);
        end else begin
            n = $urandom_range(1, 8);
            repeat (n)
                send_byte(CHAR_UC_A + 8'($urandom_range(0, 25)) +
                          ($urandom_range(0, 1) ? CASE_DIFF : 8'h00));
            send_byte(CHAR_NL);
        end
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            fetch();
        end else if (sel == 7) begin
            fetch();
            fetch();
        end
    endtask

    task automatic test_idle_fetch();
        fetch();
        send_byte(CHAR_NL);
        send_byte(CHAR_NUL);
        fetch();
    endtask

    task automatic test_trimmed_keyword();
        send_byte(CHAR_SP);
        send_text("nO");
        send_byte(CHAR_CR);
        send_byte(CHAR_SP);
        send_byte(CHAR_NL);
        fetch();
    endtask

    task automatic test_blank_line();
        send_text("  ");
        send_byte(CHAR_NL);
        fetch();
    endtask

    task automatic test_full_mailbox();
        send_text("up");
        send_byte(CHAR_NL);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(CHAR_NL);
        fetch();
        fetch();
    endtask

    task automatic test_random_lines(input int target, input int gap_max, input int stall_max);
        src_gap_max   = gap_max;
        snk_stall_max = stall_max;
        while (words_counted < target)
            random_line();
        drain();
    endtask

    // result side: random stalls, then compare each word with the oldest prediction
    initial begin
        int             stall;
        keyword_reply_t want;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = $urandom_range(0, snk_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            if (awaited_replies.size() == 0) begin
                count_failure($sformatf("unexpected word: code %0d pending %0d",
                                        m_tdata[3:0], m_tdata[4]));
            end else begin
                want = awaited_replies.pop_front();
                if (m_tdata[3:0] !== want.code)
                    count_failure($sformatf("command_code mismatch: expected %0d, got %0d",
                                            want.code, m_tdata[3:0]));
                if (m_tdata[4] !== want.pending)
                    count_failure($sformatf("pending mismatch: expected %0d, got %0d",
                                            want.pending, m_tdata[4]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        failures      = 0;
        words_counted = 0;
        quiet_cycles  = 0;
        src_gap_max   = 9;
        snk_stall_max = 9;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_BYTE;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        clear_line();
        mailbox_code = CODE_NONE;
        mailbox_full = 1'b0;

        test_idle_fetch();
        test_trimmed_keyword();
        test_blank_line();
        test_full_mailbox();
        drain();
        test_random_lines(500, 9, 9);
        test_random_lines(650, 0, 0);
        test_random_lines(750, 0, 9);
        test_random_lines(850, 9, 0);

        repeat (8) @(posedge aclk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/lckr_pkg.sv
sv/line_command_keyword_receiver.sv
sv/lckr_checker.sv
bench/tb_line_command_keyword_receiver.sv
